// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define CHK_ALWAYS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Types and constants of the core hotplug decision block.
// ----------------------------------------------------------------------------
package chd_pkg;

	localparam int NUM_CORES = 4;
	localparam int COUNT_W   = 3;
	localparam int RATE_W    = 22;
	localparam logic [3:0] CORE_MASK = 4'((1 << NUM_CORES) - 1);

	localparam int IN_W  = 136;
	localparam int OUT_W = 8;
	localparam int CFG_W = 64;

	typedef enum logic [1:0] {
		DEC_DISABLED = 2'd0,
		DEC_IDLE     = 2'd1,
		DEC_DOWN     = 2'd2,
		DEC_UP       = 2'd3
	} dec_t;

	typedef enum logic [2:0] {
		CFG_ENABLE    = 3'd0,
		CFG_MIN_CORES = 3'd1,
		CFG_MAX_CORES = 3'd2,
		CFG_IDLE_RATE = 3'd3,
		CFG_PAUSE     = 3'd4,
		CFG_DEPTH_THR = 3'd5,
		CFG_UP_TIME   = 3'd6,
		CFG_DOWN_TIME = 3'd7
	} cfg_idx_t;

	// Input word, lowest field at the bottom of the struct.
	typedef struct packed {
		logic [3:0]        pad;
		logic [RATE_W-1:0] rate_core3;
		logic [RATE_W-1:0] rate_core2;
		logic [RATE_W-1:0] rate_core1;
		logic [RATE_W-1:0] rate_core0;
		logic [3:0]        actual_online;
		logic [7:0]        run_queue_depth;
		logic [31:0]       now_ms;
	} in_word_t;

	typedef struct packed {
		logic       pad;
		logic       skipped;
		logic       conflict_paused;
		logic       command_issued;
		logic [1:0] target_core;
		dec_t       decision;
	} out_word_t;

endpackage

// File: sv/cpu_hotplug_decision.sv
// ----------------------------------------------------------------------------
// cpu_hotplug_decision
// Governor tick evaluation: picks idle, core up or core down per tick, or reports disabled or skipped.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one tick word (now_ms, run_queue_depth,
//   actual_online, rate_core0..3); master stream m_* returns one decision
//   word per tick. A word moves when tvalid and tready are both high.
//   m_tvalid rises once the accepted word has passed the input register
//   and the result register: the tick is captured in an input register,
//   evaluated by one pass of compare and four-way minimum logic, and
//   written to the result register together with the governor state. One
//   tick is taken every cycle while the receiver does not stall; the state
//   written by a tick is seen by the tick right behind it.
//   When the receiver stalls, the result register holds; an empty input
//   register still takes one more word, and once it is full s_tready
//   follows m_tready in the same cycle.
//   Reset clears both valid flags, loads the default thresholds and limits,
//   marks the online belief all ones with a resync pending, and leaves the
//   governor disabled. The user writes configuration on cfg_we only while
//   the block is idle (not enforced); setting enable from 0 requests a fresh resync.
// ----------------------------------------------------------------------------
module cpu_hotplug_decision (
	input  logic                        clk,
	input  logic                        arst_n,
	// now_ms, run_queue_depth, actual_online, rate_core0..rate_core3, pad
	input  logic [chd_pkg::IN_W-1:0]    s_tdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// decision, target_core, command_issued, conflict_paused, skipped, pad
	output logic [chd_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [chd_pkg::CFG_W-1:0]   cfg_data
);

	// configuration
	logic        enable_q;
	logic [2:0]  min_cores_q;
	logic [2:0]  max_cores_q;
	logic [21:0] idle_rate_q;
	logic [15:0] pause_ms_q;
	logic [63:0] depth_thr_q;
	logic [63:0] up_time_q;
	logic [63:0] down_time_q;

	// governor state
	logic [3:0]  believed_q;
	logic        resync_q;
	logic        first_q;
	logic [31:0] prev_time_q;
	logic [31:0] acc_time_q;
	logic [31:0] pause_until_q;
	logic        pause_valid_q;

	// pipeline
	chd_pkg::in_word_t  tick_s1;
	logic               valid_s1;
	chd_pkg::out_word_t res_q;
	logic               out_valid_q;
	logic               adv;

	// next state from the evaluation
	chd_pkg::out_word_t res;
	logic [3:0]  nx_believed;
	logic        nx_resync;
	logic        nx_first;
	logic [31:0] nx_prev;
	logic [31:0] nx_acc;
	logic [31:0] nx_pause_until;
	logic        nx_pause_valid;

	logic [3:0]                   act;
	logic [chd_pkg::COUNT_W-1:0]  n_online;
	logic [chd_pkg::RATE_W-1:0]   rates [chd_pkg::NUM_CORES];
	logic [1:0]                   k;

	assign act = tick_s1.actual_online & chd_pkg::CORE_MASK;
	assign rates[0] = tick_s1.rate_core0;
	assign rates[1] = tick_s1.rate_core1;
	if (chd_pkg::NUM_CORES > 2) begin : g_rate2
		assign rates[2] = tick_s1.rate_core2;
	end
	if (chd_pkg::NUM_CORES > 3) begin : g_rate3
		assign rates[3] = tick_s1.rate_core3;
	end

	always_comb begin
		n_online = '0;
		for (int c = 0; c < chd_pkg::NUM_CORES; c++) begin
			n_online = n_online + chd_pkg::COUNT_W'(act[c]);
		end
	end

	assign k = 2'(n_online - chd_pkg::COUNT_W'(1));

	always_comb begin
		logic [31:0] pdiff;
		logic        skip;
		logic [3:0]  bel;
		logic [31:0] elapsed;
		logic [32:0] sum;
		logic [31:0] acc_v;
		logic [21:0] slowest;
		logic        have;
		logic [21:0] best;
		logic        found;
		logic [1:0]  tgt;
		logic        b_bit;
		logic        a_bit;
		logic        want;
		chd_pkg::dec_t dec;

		res            = '0;
		res.decision   = chd_pkg::DEC_DISABLED;
		nx_believed    = believed_q;
		nx_resync      = resync_q;
		nx_first       = first_q;
		nx_prev        = prev_time_q;
		nx_acc         = acc_time_q;
		nx_pause_until = pause_until_q;
		nx_pause_valid = pause_valid_q;
		elapsed = '0;
		sum     = '0;
		acc_v   = '0;
		slowest = '0;
		have    = 1'b0;
		best    = '0;
		found   = 1'b0;
		tgt     = '0;
		b_bit   = 1'b0;
		a_bit   = 1'b0;
		want    = 1'b0;
		dec     = chd_pkg::DEC_DISABLED;

		// window is live while pause_until is at or after now (modular)
		pdiff = pause_until_q - tick_s1.now_ms;
		skip  = pause_valid_q && !pdiff[31];
		bel   = resync_q ? act : believed_q;

		if (skip) begin
			res.skipped = 1'b1;
		end else begin
			nx_pause_valid = 1'b0;
			nx_resync      = 1'b0;
			if (enable_q) begin
				elapsed  = first_q ? 32'd0 : tick_s1.now_ms - prev_time_q;
				nx_first = 1'b0;
				sum      = {1'b0, acc_time_q} + {1'b0, elapsed};
				acc_v    = sum[32] ? '1 : sum[31:0];

				for (int c = 0; c < chd_pkg::NUM_CORES; c++) begin
					if (act[c] && (!have || rates[c] < slowest)) begin
						slowest = rates[c];
						have    = 1'b1;
					end
				end

				dec = chd_pkg::DEC_IDLE;
				if (n_online == '0) begin
					acc_v = '0;
				end else if (n_online < chd_pkg::COUNT_W'(chd_pkg::NUM_CORES) &&
						tick_s1.run_queue_depth >= depth_thr_q[{k, 4'b0000} +: 8]) begin
					if (acc_v >= {16'd0, up_time_q[{k, 4'b0000} +: 16]} &&
							n_online < max_cores_q) begin
						dec = (slowest <= idle_rate_q) ? chd_pkg::DEC_IDLE : chd_pkg::DEC_UP;
					end
				end else if (n_online > chd_pkg::COUNT_W'(1) &&
						tick_s1.run_queue_depth <= depth_thr_q[{k, 4'b1000} +: 8]) begin
					if (acc_v >= {16'd0, down_time_q[{k, 4'b0000} +: 16]} &&
							n_online > min_cores_q) begin
						dec = (slowest > idle_rate_q) ? chd_pkg::DEC_IDLE : chd_pkg::DEC_DOWN;
					end
				end else begin
					acc_v = '0;
				end
				if (dec != chd_pkg::DEC_IDLE) begin
					acc_v = '0;
				end
				nx_acc  = acc_v;
				nx_prev = tick_s1.now_ms;

				// up: lowest offline core from 1; down: slowest online core from 1, last on ties
				for (int c = 1; c < chd_pkg::NUM_CORES; c++) begin
					if (dec == chd_pkg::DEC_UP) begin
						if (!found && !act[c]) begin
							tgt   = 2'(c);
							found = 1'b1;
						end
					end else if (act[c] && (!found || rates[c] <= best)) begin
						best  = rates[c];
						tgt   = 2'(c);
						found = 1'b1;
					end
				end

				res.decision = dec;
				if ((dec == chd_pkg::DEC_UP || dec == chd_pkg::DEC_DOWN) && found) begin
					b_bit = bel[tgt];
					a_bit = act[tgt];
					want  = (dec == chd_pkg::DEC_DOWN);
					res.target_core = tgt;
					if (b_bit == want && a_bit == want) begin
						res.command_issued = 1'b1;
						bel[tgt] = !want;
					end else if (b_bit != a_bit) begin
						// outside interference: pause and relearn the mask
						res.conflict_paused = 1'b1;
						nx_pause_until = tick_s1.now_ms + {16'd0, pause_ms_q};
						nx_pause_valid = 1'b1;
						nx_resync      = 1'b1;
					end
				end
			end
			nx_believed = bel;
		end
	end

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= chd_pkg::in_word_t'(s_tdata);
		end
		if (valid_s1 && adv) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			enable_q      <= 1'b0;
			min_cores_q   <= 3'd1;
			max_cores_q   <= 3'd4;
			idle_rate_q   <= 22'd499200;
			pause_ms_q    <= 16'd10000;
			depth_thr_q   <= 64'd1297047795291914252;
			up_time_q     <= 64'd601304596620;
			down_time_q   <= 64'd53481061631262720;
			believed_q    <= chd_pkg::CORE_MASK;
			resync_q      <= 1'b1;
			first_q       <= 1'b1;
			prev_time_q   <= '0;
			acc_time_q    <= '0;
			pause_until_q <= '0;
			pause_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
			if (valid_s1 && adv) begin
				believed_q    <= nx_believed;
				resync_q      <= nx_resync;
				first_q       <= nx_first;
				prev_time_q   <= nx_prev;
				acc_time_q    <= nx_acc;
				pause_until_q <= nx_pause_until;
				pause_valid_q <= nx_pause_valid;
			end
			if (cfg_we) begin
				case (chd_pkg::cfg_idx_t'(cfg_index))
					chd_pkg::CFG_ENABLE: begin
						if (!enable_q && cfg_data[0]) begin
							resync_q <= 1'b1;
						end
						enable_q <= cfg_data[0];
					end
					chd_pkg::CFG_MIN_CORES: min_cores_q <= cfg_data[2:0];
					chd_pkg::CFG_MAX_CORES: max_cores_q <= cfg_data[2:0];
					chd_pkg::CFG_IDLE_RATE: idle_rate_q <= cfg_data[21:0];
					chd_pkg::CFG_PAUSE:     pause_ms_q  <= cfg_data[15:0];
					chd_pkg::CFG_DEPTH_THR: depth_thr_q <= cfg_data;
					chd_pkg::CFG_UP_TIME:   up_time_q   <= cfg_data;
					chd_pkg::CFG_DOWN_TIME: down_time_q <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

endmodule

// File: sv/chd_checker.sv
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks on the decision stream of cpu_hotplug_decision.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chd_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [chd_pkg::OUT_W-1:0] m_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready
);

	chd_pkg::out_word_t word;
	logic               acted;

	assign word  = chd_pkg::out_word_t'(m_tdata);
	assign acted = word.decision == chd_pkg::DEC_UP || word.decision == chd_pkg::DEC_DOWN;

	// a skipped tick carries nothing else
	`CHK_IMPLY(a_skip_empty, clk, arst_n, m_tvalid && word.skipped, word.decision == chd_pkg::DEC_DISABLED && word.target_core == 2'd0 && !word.command_issued && !word.conflict_paused, "skipped word carries a decision")

	// a command or a conflict only follows an up or down on a core above 0
	`CHK_IMPLY(a_act_target, clk, arst_n, m_tvalid && (word.command_issued || word.conflict_paused), acted && word.target_core != 2'd0, "command or conflict without a core action")

	`CHK_ALWAYS(a_cmd_xor_conf, clk, arst_n, !(m_tvalid && word.command_issued && word.conflict_paused), "command and conflict in the same word")

	// hold the word while the receiver stalls
	`CHK_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed during stall")

endmodule

bind cpu_hotplug_decision chd_checker u_chd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
